[hw/rtl/rfg_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rfg_pkg : shared widths, types and constant functions
// Field widths, inter-module structs and the exp2 coefficient table builder
// of the radial falloff texel generator.
// ----------------------------------------------------------------------------
package rfg_pkg;

    localparam int IDX_W      = 8;    // row / column
    localparam int SIZE_W     = 9;    // image_size
    localparam int POW_W      = 8;    // falloff_power, Q4.4
    localparam int POW_FRAC   = 4;
    localparam int RGBA_W     = 32;
    localparam int CH_W       = 8;
    localparam int Q_W        = 15;   // axis magnitude fraction bits
    localparam int T_W        = 16;   // t = 1 - d, Q.15, up to 1.0
    localparam int L_W        = 20;   // -log2 t, Q.16
    localparam int PROD_W     = POW_W + L_W;
    localparam int E_W        = PROD_W - POW_FRAC;
    localparam int G_W        = 31;   // exp2 accumulator, Q.30
    localparam int COEF_W     = 30;
    localparam int F_W        = 17;   // falloff, Q.16, up to 1.0
    localparam int LOG_STEPS  = 16;
    localparam int EXP_STEPS  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [T_W-1:0] T_ONE = 16'h8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_SIZE      = 2'd0,
        REG_FALLOFF_POWER   = 2'd1,
        REG_CENTER_RGBA     = 2'd2,
        REG_BACKGROUND_RGBA = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic           zero;
        logic [T_W-1:0] t;
    } dist_t;

    typedef struct packed {
        logic        zero;
        logic [3:0]  ipart;
        logic [15:0] fpart;
    } exp_arg_t;

    // integer square root, evaluated at elaboration only
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        rem  = v;
        res  = '0;
        bitv = 64'h1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (rem >= res + bitv)
            begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Q.30 value of 2^(-2^-(j+1))
    function automatic logic [COEF_W-1:0] exp_coef(input int j);
        logic [63:0] c;
        c = isqrt64(64'h1 << 59);
        for (int i = 0; i < j; i++)
        begin
            c = isqrt64(c << 30);
        end
        return c[COEF_W-1:0];
    endfunction

endpackage
`default_nettype wire

[hw/rtl/rfg_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rfg_if : stream channels
// Texel position channel in, blended pixel channel out; valid/ready.
// ----------------------------------------------------------------------------
interface rfg_texel_if;
    import rfg_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] column;
    modport source (output valid, output row, output column, input ready);
    modport sink   (input valid, input row, input column, output ready);
endinterface

interface rfg_pixel_if;
    import rfg_pkg::*;
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
    modport source (output valid, output red, output green, output blue, output alpha,
                    input ready);
    modport sink   (input valid, input red, input green, input blue, input alpha,
                    output ready);
endinterface
`default_nettype wire

[hw/rtl/rfg_distance.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rfg_distance : texel position to t = 1 - d
// Axis offsets divided by the side length (restoring, pipelined), squared,
// summed and passed through a pipelined digit-by-digit square root.
// ----------------------------------------------------------------------------
module rfg_distance (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire logic [rfg_pkg::IDX_W-1:0]  row,
    input  wire logic [rfg_pkg::IDX_W-1:0]  column,
    input  wire logic [rfg_pkg::SIZE_W-1:0] image_size,
    output logic                           out_valid,
    output rfg_pkg::dist_t                 out_dist
);
    import rfg_pkg::*;

    localparam int DIV_PER     = 4;
    localparam int DIV_STAGES  = (Q_W + DIV_PER - 1) / DIV_PER;
    localparam int SQRT_PER    = 4;
    localparam int SQRT_STAGES = (Q_W + SQRT_PER - 1) / SQRT_PER;
    localparam int D2_W        = 2 * Q_W;
    localparam int AX_W        = IDX_W + 3;

    logic [IDX_W-1:0]  idx [2];
    logic [SIZE_W-1:0] size_eff;
    logic [SIZE_W-1:0] mag_next [2];
    logic              ovf_next;

    logic              div_vld_reg  [DIV_STAGES+1];
    logic              div_ovf_reg  [DIV_STAGES+1];
    logic [SIZE_W-1:0] div_size_reg [DIV_STAGES+1];
    logic [SIZE_W-1:0] div_rem_reg  [DIV_STAGES+1][2];
    logic [Q_W-1:0]    div_quo_reg  [DIV_STAGES+1][2];

    logic              sq_vld_reg;
    logic              sq_ovf_reg;
    logic [D2_W-1:0]   sq_reg [2];

    logic              rt_vld_reg  [SQRT_STAGES+1];
    logic              rt_zero_reg [SQRT_STAGES+1];
    logic [D2_W:0]     rt_rem_reg  [SQRT_STAGES+1];
    logic [D2_W:0]     rt_res_reg  [SQRT_STAGES+1];

    logic [D2_W:0]     d2_sum;

    assign idx[0] = column;
    assign idx[1] = row;

    // offset magnitude |2 idx - (S-1)|; at or beyond S the distance is past one
    always_comb
    begin
        logic [SIZE_W-1:0] size_m1;
        logic [AX_W-1:0]   diff;
        logic [AX_W-1:0]   mag;
        size_eff = (image_size == '0) ? SIZE_W'(1) : image_size;
        size_m1  = size_eff - SIZE_W'(1);
        for (int a = 0; a < 2; a++)
        begin
            diff        = {2'b00, idx[a], 1'b0} - {2'b00, size_m1};
            mag         = diff[AX_W-1] ? (~diff + AX_W'(1)) : diff;
            mag_next[a] = mag[SIZE_W-1:0];
        end
        ovf_next = (mag_next[0] >= size_eff) || (mag_next[1] >= size_eff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_vld_reg[0] <= 1'b0;
        else if (en)
            div_vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_ovf_reg[0]  <= ovf_next;
            div_size_reg[0] <= size_eff;
            for (int a = 0; a < 2; a++)
            begin
                div_rem_reg[0][a] <= mag_next[a];
                div_quo_reg[0][a] <= '0;
            end
        end
    end

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        logic [SIZE_W-1:0] rem_next [2];
        logic [Q_W-1:0]    quo_next [2];

        always_comb
        begin
            logic [SIZE_W:0]   trial;
            logic [SIZE_W-1:0] rem;
            logic [Q_W-1:0]    quo;
            for (int a = 0; a < 2; a++)
            begin
                rem = div_rem_reg[g][a];
                quo = div_quo_reg[g][a];
                for (int k = 0; k < DIV_PER; k++)
                begin
                    if (g * DIV_PER + k < Q_W)
                    begin
                        trial = {rem, 1'b0};
                        if (trial >= {1'b0, div_size_reg[g]})
                        begin
                            trial = trial - {1'b0, div_size_reg[g]};
                            quo   = {quo[Q_W-2:0], 1'b1};
                        end
                        else
                        begin
                            quo = {quo[Q_W-2:0], 1'b0};
                        end
                        rem = trial[SIZE_W-1:0];
                    end
                end
                rem_next[a] = rem;
                quo_next[a] = quo;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                div_vld_reg[g+1] <= 1'b0;
            else if (en)
                div_vld_reg[g+1] <= div_vld_reg[g];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_ovf_reg[g+1]  <= div_ovf_reg[g];
                div_size_reg[g+1] <= div_size_reg[g];
                for (int a = 0; a < 2; a++)
                begin
                    div_rem_reg[g+1][a] <= rem_next[a];
                    div_quo_reg[g+1][a] <= quo_next[a];
                end
            end
        end
    end

    // square each axis
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_vld_reg <= 1'b0;
        else if (en)
            sq_vld_reg <= div_vld_reg[DIV_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_ovf_reg <= div_ovf_reg[DIV_STAGES];
            for (int a = 0; a < 2; a++)
            begin
                sq_reg[a] <= {{Q_W{1'b0}}, div_quo_reg[DIV_STAGES][a]}
                           * {{Q_W{1'b0}}, div_quo_reg[DIV_STAGES][a]};
            end
        end
    end

    // sum, and drop to zero falloff at or beyond unit distance
    assign d2_sum = {1'b0, sq_reg[0]} + {1'b0, sq_reg[1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rt_vld_reg[0] <= 1'b0;
        else if (en)
            rt_vld_reg[0] <= sq_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rt_zero_reg[0] <= sq_ovf_reg | d2_sum[D2_W];
            rt_rem_reg[0]  <= {1'b0, d2_sum[D2_W-1:0]};
            rt_res_reg[0]  <= '0;
        end
    end

    for (genvar h = 0; h < SQRT_STAGES; h++)
    begin : g_sqrt
        logic [D2_W:0] rem_next;
        logic [D2_W:0] res_next;

        always_comb
        begin
            logic [D2_W:0] rem;
            logic [D2_W:0] res;
            logic [D2_W:0] bitv;
            rem = rt_rem_reg[h];
            res = rt_res_reg[h];
            for (int k = 0; k < SQRT_PER; k++)
            begin
                if (h * SQRT_PER + k < Q_W)
                begin
                    bitv = (D2_W+1)'(1) << (2 * (Q_W - 1 - (h * SQRT_PER + k)));
                    if (rem >= res + bitv)
                    begin
                        rem = rem - (res + bitv);
                        res = (res >> 1) + bitv;
                    end
                    else
                    begin
                        res = res >> 1;
                    end
                end
            end
            rem_next = rem;
            res_next = res;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                rt_vld_reg[h+1] <= 1'b0;
            else if (en)
                rt_vld_reg[h+1] <= rt_vld_reg[h];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rt_zero_reg[h+1] <= rt_zero_reg[h];
                rt_rem_reg[h+1]  <= rem_next;
                rt_res_reg[h+1]  <= res_next;
            end
        end
    end

    assign out_valid     = rt_vld_reg[SQRT_STAGES];
    assign out_dist.zero = rt_zero_reg[SQRT_STAGES];
    assign out_dist.t    = T_ONE - {1'b0, rt_res_reg[SQRT_STAGES][Q_W-1:0]};

endmodule
`default_nettype wire

[hw/rtl/rfg_log2.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rfg_log2 : exponent argument E = power * (-log2 t)
// Normalise t, then one squaring stage per fraction bit, then scale by power.
// ----------------------------------------------------------------------------
module rfg_log2 (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     en,
    input  wire logic                     in_valid,
    input  wire rfg_pkg::dist_t           in_dist,
    input  wire logic [rfg_pkg::POW_W-1:0] falloff_power,
    output logic                          out_valid,
    output rfg_pkg::exp_arg_t             out_arg
);
    import rfg_pkg::*;

    logic             lg_vld_reg   [LOG_STEPS+1];
    logic             lg_zero_reg  [LOG_STEPS+1];
    logic [3:0]       lg_shift_reg [LOG_STEPS+1];
    logic [T_W-1:0]   lg_m_reg     [LOG_STEPS+1];
    logic [15:0]      lg_frac_reg  [LOG_STEPS+1];

    logic             pr_vld_reg;
    logic             pr_zero_reg;
    logic [PROD_W-1:0] pr_reg;

    logic [3:0]       shift_next;
    logic [T_W-1:0]   m_next;
    logic [L_W-1:0]   neg_log;
    logic [E_W-1:0]   e_val;

    // leading-one normalisation to Q1.15
    always_comb
    begin
        logic [3:0] msb;
        msb = '0;
        for (int b = 0; b < T_W; b++)
        begin
            if (in_dist.t[b])
                msb = 4'(b);
        end
        shift_next = 4'(T_W - 1) - msb;
        m_next     = in_dist.t << shift_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lg_vld_reg[0] <= 1'b0;
        else if (en)
            lg_vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lg_zero_reg[0]  <= in_dist.zero;
            lg_shift_reg[0] <= shift_next;
            lg_m_reg[0]     <= m_next;
            lg_frac_reg[0]  <= '0;
        end
    end

    for (genvar s = 0; s < LOG_STEPS; s++)
    begin : g_sq
        logic [2*T_W-1:0] sq;
        logic             hi;
        assign sq = {{T_W{1'b0}}, lg_m_reg[s]} * {{T_W{1'b0}}, lg_m_reg[s]};
        assign hi = sq[2*T_W-1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                lg_vld_reg[s+1] <= 1'b0;
            else if (en)
                lg_vld_reg[s+1] <= lg_vld_reg[s];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lg_zero_reg[s+1]  <= lg_zero_reg[s];
                lg_shift_reg[s+1] <= lg_shift_reg[s];
                // squared mantissa in [1,4): halve it when the bit is set
                lg_m_reg[s+1]     <= hi ? sq[2*T_W-1:T_W] : sq[2*T_W-2:T_W-1];
                lg_frac_reg[s+1]  <= {lg_frac_reg[s][14:0], hi};
            end
        end
    end

    assign neg_log = {lg_shift_reg[LOG_STEPS], 16'h0000} - {4'h0, lg_frac_reg[LOG_STEPS]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pr_vld_reg <= 1'b0;
        else if (en)
            pr_vld_reg <= lg_vld_reg[LOG_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr_zero_reg <= lg_zero_reg[LOG_STEPS];
            pr_reg      <= {{L_W{1'b0}}, falloff_power} * {{POW_W{1'b0}}, neg_log};
        end
    end

    assign e_val          = pr_reg[PROD_W-1:POW_FRAC];
    assign out_valid      = pr_vld_reg;
    assign out_arg.zero   = pr_zero_reg | (|e_val[E_W-1:20]);
    assign out_arg.ipart  = e_val[19:16];
    assign out_arg.fpart  = e_val[15:0];

endmodule
`default_nettype wire

[hw/rtl/rfg_exp2.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rfg_exp2 : falloff f = 2^-E in Q.16
// One constant multiply stage per fraction bit, then the integer shift.
// ----------------------------------------------------------------------------
module rfg_exp2 (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire rfg_pkg::exp_arg_t     in_arg,
    output logic                       out_valid,
    output logic [rfg_pkg::F_W-1:0]    out_falloff
);
    import rfg_pkg::*;

    localparam logic [G_W-1:0] G_ONE = 31'h4000_0000;

    logic           ex_vld_reg  [EXP_STEPS];
    logic           ex_zero_reg [EXP_STEPS];
    logic [3:0]     ex_ipart_reg[EXP_STEPS];
    logic [15:0]    ex_fpart_reg[EXP_STEPS];
    logic [G_W-1:0] ex_g_reg    [EXP_STEPS];

    logic           f_vld_reg;
    logic [F_W-1:0] f_reg;
    logic [G_W-1:0] g_shifted;

    for (genvar j = 0; j < EXP_STEPS; j++)
    begin : g_step
        localparam logic [COEF_W-1:0] COEF = exp_coef(j);
        logic                  src_vld;
        logic                  src_zero;
        logic [3:0]            src_ipart;
        logic [15:0]           src_fpart;
        logic [G_W-1:0]        src_g;
        logic [G_W+COEF_W-1:0] prod;

        if (j == 0)
        begin : g_first
            assign src_vld   = in_valid;
            assign src_zero  = in_arg.zero;
            assign src_ipart = in_arg.ipart;
            assign src_fpart = in_arg.fpart;
            assign src_g     = G_ONE;
        end
        else
        begin : g_rest
            assign src_vld   = ex_vld_reg[j-1];
            assign src_zero  = ex_zero_reg[j-1];
            assign src_ipart = ex_ipart_reg[j-1];
            assign src_fpart = ex_fpart_reg[j-1];
            assign src_g     = ex_g_reg[j-1];
        end

        assign prod = {{COEF_W{1'b0}}, src_g} * {{G_W{1'b0}}, COEF};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ex_vld_reg[j] <= 1'b0;
            else if (en)
                ex_vld_reg[j] <= src_vld;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ex_zero_reg[j]  <= src_zero;
                ex_ipart_reg[j] <= src_ipart;
                ex_fpart_reg[j] <= src_fpart;
                ex_g_reg[j]     <= src_fpart[EXP_STEPS-1-j] ?
                                   prod[G_W+COEF_W-1:COEF_W] : src_g;
            end
        end
    end

    assign g_shifted = ex_g_reg[EXP_STEPS-1] >> (5'd14 + {1'b0, ex_ipart_reg[EXP_STEPS-1]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_vld_reg <= 1'b0;
        else if (en)
            f_vld_reg <= ex_vld_reg[EXP_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            f_reg <= ex_zero_reg[EXP_STEPS-1] ? '0 : g_shifted[F_W-1:0];
    end

    assign out_valid   = f_vld_reg;
    assign out_falloff = f_reg;

endmodule
`default_nettype wire

[hw/rtl/radial_falloff_texel_generator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// radial_falloff_texel_generator : radial gradient texel colour
// Throughput: one texel per cycle while the skid register is empty; the
// pipeline holds as one while it is full, and it fills when the output stalls.
// Reset: asynchronous, active low; clears every valid bit and loads the
// registers with size 64, power 3.0, centre FFFF00FF, background 000000FF.
// ----------------------------------------------------------------------------
module radial_falloff_texel_generator (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    rfg_texel_if.sink                          texel,
    rfg_pixel_if.source                        pixel,
    input  wire logic                          write_enable,
    input  wire logic [rfg_pkg::CFG_IDX_W-1:0]  reg_index,
    input  wire logic [rfg_pkg::CFG_DATA_W-1:0] write_data
);
    import rfg_pkg::*;

    localparam logic [SIZE_W-1:0] SIZE_RST       = 9'd64;
    localparam logic [POW_W-1:0]  POWER_RST      = 8'd48;
    localparam logic [RGBA_W-1:0] CENTER_RST     = 32'hFFFF_00FF;
    localparam logic [RGBA_W-1:0] BACKGROUND_RST = 32'h0000_00FF;

    // configuration registers; the user must write them only while idle,
    // which the block does not enforce, so every stage reads them live
    logic [SIZE_W-1:0] image_size_reg;
    logic [POW_W-1:0]  falloff_power_reg;
    logic [RGBA_W-1:0] center_rgba_reg;
    logic [RGBA_W-1:0] background_rgba_reg;

    // one enable for the whole pipe: advance unless the skid register is full
    logic              en;

    logic              dist_valid;
    dist_t             dist_item;
    logic              arg_valid;
    exp_arg_t          arg;
    logic              f_valid;
    logic [F_W-1:0]    falloff;

    logic [RGBA_W-1:0] blend_next;
    logic              blend_vld_reg;
    logic [RGBA_W-1:0] blend_reg;

    logic              out_valid_reg;
    logic [RGBA_W-1:0] out_data_reg;
    logic              skid_valid_reg;
    logic [RGBA_W-1:0] skid_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_size_reg      <= SIZE_RST;
            falloff_power_reg   <= POWER_RST;
            center_rgba_reg     <= CENTER_RST;
            background_rgba_reg <= BACKGROUND_RST;
        end
        else if (write_enable)
        begin
            unique case (cfg_reg_t'(reg_index))
                REG_IMAGE_SIZE:      image_size_reg      <= write_data[SIZE_W-1:0];
                REG_FALLOFF_POWER:   falloff_power_reg   <= write_data[POW_W-1:0];
                REG_CENTER_RGBA:     center_rgba_reg     <= write_data[RGBA_W-1:0];
                REG_BACKGROUND_RGBA: background_rgba_reg <= write_data[RGBA_W-1:0];
            endcase
        end
    end

    assign en          = !skid_valid_reg;
    assign texel.ready = en;

    // distance: front end, divide, square, sum, square root (11 stages)
    rfg_distance u_distance (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (texel.valid),
        .row        (texel.row),
        .column     (texel.column),
        .image_size (image_size_reg),
        .out_valid  (dist_valid),
        .out_dist   (dist_item)
    );

    // log2 and power scaling (18 stages)
    rfg_log2 u_log2 (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (dist_valid),
        .in_dist       (dist_item),
        .falloff_power (falloff_power_reg),
        .out_valid     (arg_valid),
        .out_arg       (arg)
    );

    // exp2 back to the falloff (17 stages)
    rfg_exp2 u_exp2 (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (arg_valid),
        .in_arg      (arg),
        .out_valid   (f_valid),
        .out_falloff (falloff)
    );

    // blend each byte: centre*f + background*(1-f), truncated
    always_comb
    begin
        logic [F_W-1:0]      inv;
        logic [CH_W-1:0]     c;
        logic [CH_W-1:0]     b;
        logic [CH_W+F_W-1:0] mix;
        inv = {1'b1, {(F_W-1){1'b0}}} - falloff;
        for (int ch = 0; ch < RGBA_W / CH_W; ch++)
        begin
            c   = center_rgba_reg[RGBA_W-1-CH_W*ch -: CH_W];
            b   = background_rgba_reg[RGBA_W-1-CH_W*ch -: CH_W];
            mix = ({{F_W{1'b0}}, c} * {{CH_W{1'b0}}, falloff})
                + ({{F_W{1'b0}}, b} * {{CH_W{1'b0}}, inv});
            blend_next[RGBA_W-1-CH_W*ch -: CH_W] = mix[CH_W+F_W-2:F_W-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            blend_vld_reg <= 1'b0;
        else if (en)
            blend_vld_reg <= f_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            blend_reg <= blend_next;
    end

    // output register with skid: hold the waiting item, park the next one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pixel.ready)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || pixel.ready)
        begin
            out_valid_reg <= blend_vld_reg;
        end
        else if (blend_vld_reg)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pixel.ready)
                out_data_reg <= skid_data_reg;
        end
        else if (!out_valid_reg || pixel.ready)
        begin
            out_data_reg <= blend_reg;
        end
        else
        begin
            skid_data_reg <= blend_reg;
        end
    end

    assign pixel.valid = out_valid_reg;
    assign pixel.red   = out_data_reg[31:24];
    assign pixel.green = out_data_reg[23:16];
    assign pixel.blue  = out_data_reg[15:8];
    assign pixel.alpha = out_data_reg[7:0];

    // skid holds an item only behind a waiting output item
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full with output register empty");

    // skid fills only after the output was offered and refused
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !pixel.ready))
        else $error("skid register filled without an output stall");

    // a parked item is never dropped while the output still stalls
    a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !pixel.ready |=> skid_valid_reg && $stable(skid_data_reg))
        else $error("parked item lost under output stall");

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radial falloff texel generator testbench
// Streams texel positions through the block under a series of register
// settings, predicts each blended pixel not stated in the table with a local
// fixed-point model and compares the output in order, channel by channel.
// ----------------------------------------------------------------------------
module testbench;
    import rfg_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic write_enable = 1'b0;
    logic [CFG_IDX_W-1:0] reg_index = '0;
    logic [CFG_DATA_W-1:0] write_data = '0;

    rfg_texel_if texel ();
    rfg_pixel_if pixel ();

    radial_falloff_texel_generator u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .texel        (texel.sink),
        .pixel        (pixel.source),
        .write_enable (write_enable),
        .reg_index    (reg_index),
        .write_data   (write_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // One row of the directed table: the settings to run under, the texel,
    // and the pixel where it can be stated outright.
    typedef struct {
        logic [SIZE_W-1:0] size;
        logic [POW_W-1:0]  power;
        logic [RGBA_W-1:0] centre;
        logic [RGBA_W-1:0] backdrop;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  column;
        bit                stated;
        logic [RGBA_W-1:0] pixel_rgba;
    } texel_case_t;

    localparam int CASES = 20;
    localparam int LATENCY_WAIT = 80;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_ITEMS = 56;

    texel_case_t cases [CASES] = '{
        // reset settings: corners lie beyond the disc and take the backdrop
        '{9'd64, 8'd48, 32'hFFFF00FF, 32'h000000FF, 8'd0,   8'd0,   1'b1, 32'h000000FF},
        '{9'd64, 8'd48, 32'hFFFF00FF, 32'h000000FF, 8'd255, 8'd255, 1'b1, 32'h000000FF},
        '{9'd64, 8'd48, 32'hFFFF00FF, 32'h000000FF, 8'd0,   8'd255, 1'b1, 32'h000000FF},
        '{9'd64, 8'd48, 32'hFFFF00FF, 32'h000000FF, 8'd31,  8'd32,  1'b0, 32'h0},
        '{9'd64, 8'd48, 32'hFFFF00FF, 32'h000000FF, 8'd32,  8'd32,  1'b0, 32'h0},
        '{9'd64, 8'd48, 32'hFFFF00FF, 32'h000000FF, 8'd10,  8'd40,  1'b0, 32'h0},
        // one-texel image: its only texel sits at the centre
        '{9'd1,  8'd48, 32'hFFFF00FF, 32'h000000FF, 8'd0,   8'd0,   1'b1, 32'hFFFF00FF},
        '{9'd1,  8'd48, 32'hFFFF00FF, 32'h000000FF, 8'd0,   8'd1,   1'b0, 32'h0},
        // zero power: centre inside the disc, backdrop outside it
        '{9'd64, 8'd0,  32'hFFFF00FF, 32'h000000FF, 8'd32,  8'd32,  1'b1, 32'hFFFF00FF},
        '{9'd64, 8'd0,  32'hFFFF00FF, 32'h000000FF, 8'd0,   8'd0,   1'b1, 32'h000000FF},
        // full power, extreme colours
        '{9'd256, 8'd255, 32'hFFFFFFFF, 32'h0, 8'd128, 8'd128, 1'b0, 32'h0},
        '{9'd256, 8'd255, 32'hFFFFFFFF, 32'h0, 8'd0,   8'd0,   1'b1, 32'h0},
        '{9'd256, 8'd255, 32'hFFFFFFFF, 32'h0, 8'd255, 8'd255, 1'b1, 32'h0},
        '{9'd256, 8'd255, 32'hFFFFFFFF, 32'h0, 8'd127, 8'd128, 1'b0, 32'h0},
        '{9'd256, 8'd255, 32'hFFFFFFFF, 32'h0, 8'd100, 8'd140, 1'b0, 32'h0},
        // size above 256
        '{9'd511, 8'd16, 32'h0, 32'hFFFFFFFF, 8'd255, 8'd255, 1'b0, 32'h0},
        '{9'd511, 8'd16, 32'h0, 32'hFFFFFFFF, 8'd0,   8'd0,   1'b0, 32'h0},
        // size zero behaves as size one
        '{9'd0, 8'd16, 32'h12345678, 32'h87654321, 8'd0, 8'd0, 1'b1, 32'h12345678},
        '{9'd0, 8'd16, 32'h12345678, 32'h87654321, 8'd1, 8'd1, 1'b0, 32'h0},
        '{9'd0, 8'd16, 32'h12345678, 32'h87654321, 8'd255, 8'd0, 1'b0, 32'h0}
    };

    // Local copy of the registers, as written
    logic [SIZE_W-1:0] cur_size     = 9'd64;
    logic [POW_W-1:0]  cur_power    = 8'd48;
    logic [RGBA_W-1:0] cur_centre   = 32'hFFFF00FF;
    logic [RGBA_W-1:0] cur_backdrop = 32'h000000FF;

    longint unsigned exp2_coef [EXP_STEPS];

    logic [RGBA_W-1:0] pending_pixels [$];  // pixels still owed by the block
    bit                stated_flags [$];    // per offered texel: value stated?
    logic [RGBA_W-1:0] stated_values [$];

    int  mismatches = 0;
    bit  calm = 1'b0;          // no idling on either side
    bit  hold_request = 1'b0;  // ask the receiver for a long hold-off
    int  hold_left = 0;

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res;
        longint unsigned probe;
        res = 0;
        probe = 64'h1 << 62;
        while (probe > v)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (v >= res + probe)
            begin
                v = v - (res + probe);
                res = (res >> 1) + probe;
            end
            else
                res = res >> 1;
            probe = probe >> 2;
        end
        return res;
    endfunction

    // |2*idx - (s-1)| / s in Q.15
    function automatic longint unsigned axis_offset(int unsigned idx, int unsigned s);
        longint n;
        longint unsigned mag;
        n = longint'(2 * idx) - longint'(s - 1);
        mag = (n < 0) ? -n : n;
        return (mag * 32768) / s;
    endfunction

    // falloff t^power in Q.16, 0..65536
    function automatic int unsigned falloff_q16(int unsigned row, int unsigned column);
        int unsigned s;
        longint unsigned dx;
        longint unsigned dy;
        longint unsigned d2;
        longint unsigned m;
        longint unsigned g;
        int unsigned t;
        int unsigned k;
        int unsigned frac;
        int unsigned neg_log;
        int unsigned e;
        int unsigned ipart;
        int unsigned fpart;
        s = (cur_size == 0) ? 1 : cur_size;
        dx = axis_offset(column, s);
        dy = axis_offset(row, s);
        d2 = dx * dx + dy * dy;
        if (d2 >= (64'h1 << 30))
            return 0;
        t = 32768 - int'(root_floor(d2));
        k = 15;
        while (((t >> k) & 1) == 0)
            k--;
        m = longint'(t) << (15 - k);
        frac = 0;
        // square and renormalise, one fraction bit per pass
        for (int i = 0; i < LOG_STEPS; i++)
        begin
            m = (m * m) >> 15;
            frac = frac << 1;
            if (m >= 65536)
            begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        neg_log = (15 - k) * 65536 - frac;
        e = (int'(cur_power) * neg_log) >> 4;
        ipart = e >> 16;
        fpart = e & 16'hFFFF;
        if (ipart >= 16)
            return 0;
        g = 64'h1 << 30;
        for (int i = 0; i < EXP_STEPS; i++)
            if ((fpart >> (15 - i)) & 1)
                g = (g * exp2_coef[i]) >> 30;
        return int'(g >> (14 + ipart));
    endfunction

    function automatic logic [RGBA_W-1:0] blended_pixel(logic [IDX_W-1:0] row,
                                                      logic [IDX_W-1:0] column);
        int unsigned f;
        longint unsigned c;
        longint unsigned b;
        logic [RGBA_W-1:0] rgba;
        f = falloff_q16(row, column);
        for (int j = 0; j < 4; j++)
        begin
            c = (cur_centre >> (24 - 8 * j)) & 8'hFF;
            b = (cur_backdrop >> (24 - 8 * j)) & 8'hFF;
            rgba[31 - 8 * j -: 8] = 8'((c * f + b * (65536 - f)) >> 16);
        end
        return rgba;
    endfunction

    initial
    begin
        exp2_coef[0] = root_floor(64'h1 << 59);
        for (int j = 1; j < EXP_STEPS; j++)
            exp2_coef[j] = root_floor(exp2_coef[j - 1] << 30);
    end

    // Input monitor: on every accepted texel queue the pixel it must give,
    // taken from the table where stated, else from the predictor.
    always @(posedge clk)
    begin
        if (rst_n && texel.valid && texel.ready)
        begin
            if (stated_flags.pop_front())
                pending_pixels.push_back(stated_values.pop_front());
            else
            begin
                void'(stated_values.pop_front());
                pending_pixels.push_back(blended_pixel(texel.row, texel.column));
            end
        end
    end

    // Output checker: compare each accepted pixel with the oldest owed one.
    always @(posedge clk)
    begin
        logic [RGBA_W-1:0] owed;
        if (rst_n && pixel.valid && pixel.ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("pixel with none owed: %h%h%h%h",
                       pixel.red, pixel.green, pixel.blue, pixel.alpha);
                mismatches++;
            end
            else
            begin
                owed = pending_pixels.pop_front();
                if (pixel.red !== owed[31:24])
                begin
                    $error("red: expected %h, actual %h", owed[31:24], pixel.red);
                    mismatches++;
                end
                if (pixel.green !== owed[23:16])
                begin
                    $error("green: expected %h, actual %h", owed[23:16], pixel.green);
                    mismatches++;
                end
                if (pixel.blue !== owed[15:8])
                begin
                    $error("blue: expected %h, actual %h", owed[15:8], pixel.blue);
                    mismatches++;
                end
                if (pixel.alpha !== owed[7:0])
                begin
                    $error("alpha: expected %h, actual %h", owed[7:0], pixel.alpha);
                    mismatches++;
                end
            end
        end
    end

    // Receiver: drop ready about one cycle in ten; on request hold it low for
    // a long stretch so that the pipeline fills and stalls the texel side.
    initial pixel.ready = 1'b0;
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            pixel.ready <= 1'b0;
        end
        else if (hold_request)
        begin
            hold_request <= 1'b0;
            hold_left <= 300;
            pixel.ready <= 1'b0;
        end
        else
            pixel.ready <= calm || ($urandom_range(99) >= 10);
    end

    // Step past the last accept so its owed pixel is queued, wait until
    // nothing is owed, then let the pipeline run dry.
    task automatic drain_pipeline();
        @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (LATENCY_WAIT) @(posedge clk);
    endtask

    // Write all four registers back to back while the block is idle.
    task automatic load_settings(logic [SIZE_W-1:0] size, logic [POW_W-1:0] power,
                                 logic [RGBA_W-1:0] centre, logic [RGBA_W-1:0] backdrop);
        drain_pipeline();
        write_enable <= 1'b1;
        reg_index <= REG_IMAGE_SIZE;
        write_data <= CFG_DATA_W'(size);
        @(posedge clk);
        reg_index <= REG_FALLOFF_POWER;
        write_data <= CFG_DATA_W'(power);
        @(posedge clk);
        reg_index <= REG_CENTER_RGBA;
        write_data <= centre;
        @(posedge clk);
        reg_index <= REG_BACKGROUND_RGBA;
        write_data <= backdrop;
        @(posedge clk);
        write_enable <= 1'b0;
        cur_size = size;
        cur_power = power;
        cur_centre = centre;
        cur_backdrop = backdrop;
    endtask

    // Offer one texel and hold it until taken; then maybe idle a while.
    task automatic offer_texel(logic [IDX_W-1:0] row, logic [IDX_W-1:0] column,
                               bit stated, logic [RGBA_W-1:0] value);
        stated_flags.push_back(stated);
        stated_values.push_back(value);
        texel.valid <= 1'b1;
        texel.row <= row;
        texel.column <= column;
        do
            @(posedge clk);
        while (!texel.ready);
        if (!calm && $urandom_range(99) < 10)
        begin
            texel.valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
    endtask

    function automatic logic [IDX_W-1:0] pick_index(int unsigned s);
        // mostly inside the image, sometimes anywhere
        if (s > 1 && $urandom_range(99) < 80)
            return IDX_W'($urandom_range((s > 256 ? 256 : s) - 1));
        return IDX_W'($urandom);
    endfunction

    initial
    begin
        logic [SIZE_W-1:0] size;
        logic [POW_W-1:0]  power;
        logic [RGBA_W-1:0] centre;
        logic [RGBA_W-1:0] backdrop;
        texel.valid = 1'b0;
        texel.row = '0;
        texel.column = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table; settings change only between runs of rows
        for (int i = 0; i < CASES; i++)
        begin
            if (cases[i].size != cur_size || cases[i].power != cur_power ||
                cases[i].centre != cur_centre || cases[i].backdrop != cur_backdrop)
            begin
                texel.valid <= 1'b0;
                load_settings(cases[i].size, cases[i].power,
                              cases[i].centre, cases[i].backdrop);
            end
            offer_texel(cases[i].row, cases[i].column,
                        cases[i].stated, cases[i].pixel_rgba);
        end

        // random phases, each under its own settings
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            texel.valid <= 1'b0;
            size = SIZE_W'($urandom_range(256, 1));
            if ($urandom_range(3) == 0)
                size = SIZE_W'($urandom);
            power = POW_W'($urandom);
            centre = $urandom;
            backdrop = $urandom;
            if (p == 0)
            begin
                size = 9'd1;
                power = 8'd0;
            end
            if (p == 1)
            begin
                size = 9'd256;
                power = 8'd255;
                centre = 32'hFFFFFFFF;
                backdrop = 32'h0;
            end
            if (p == 2)
                size = 9'd4;
            load_settings(size, power, centre, backdrop);
            calm = (p == 4);
            if (p == 3)
                hold_request <= 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                offer_texel(pick_index(cur_size), pick_index(cur_size), 1'b0, '0);
        end
        texel.valid <= 1'b0;
        calm = 1'b0;

        drain_pipeline();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
